/* rtl/es_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// es_pkg: shared types and constants of the exchange sorter
// Beat layouts, the memory request bundle and the sequencer states.
// ----------------------------------------------------------------------------
package es_pkg;

   // Store geometry
   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int POS_W    = 6;

   // Input beat
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     final_item;
   } req_type;

   // Result beat
   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic [POS_W-1:0]         position;
      logic                     last_result;
      logic                     overflow;
   } rsp_type;

   // Request from the sequencer to the element store
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_CUR,
      ST_SCAN,
      ST_WRI,
      ST_EMIT
   } state_type;

endpackage

/* rtl/es_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// es_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module es_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/es_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// es_ctrl: load, sort and emit sequencer
// Streams elements into the store, runs the exchange sort with the current
// element held in a register, then reads the store out as result beats.
// ----------------------------------------------------------------------------
module es_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  es_pkg::req_type         req_data,
   input  logic                    descending,
   input  logic [es_pkg::DATA_W-1:0] rd_data,
   output logic                    busy,
   output es_pkg::mem_req_type     mem_req,
   output logic                    rsp_strobe,
   output es_pkg::rsp_type         rsp_data
);

   es_pkg::state_type state_ff, state_in;

   logic [es_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                      dropped_ff, dropped_in;
   logic [es_pkg::ADDR_W-1:0] i_ff, i_in;
   logic [es_pkg::ADDR_W-1:0] j_ff, j_in;
   logic [es_pkg::ADDR_W-1:0] k_ff, k_in;
   logic [es_pkg::DATA_W-1:0] cur_ff, cur_in;
   logic                      strobe_ff, strobe_in;
   logic [es_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic                      last_ff, last_in;
   logic                      ovf_ff, ovf_in;

   logic                      full;
   logic [es_pkg::CNT_W-1:0]  n_new;
   logic [es_pkg::ADDR_W-1:0] n_last;
   logic                      swap;

   assign full   = (count_ff == es_pkg::CNT_W'(es_pkg::CAPACITY));
   assign n_new  = full ? count_ff : count_ff + es_pkg::CNT_W'(1);
   assign n_last = es_pkg::ADDR_W'(count_ff - es_pkg::CNT_W'(1));

   // held element (position i) must follow the scanned one: exchange
   assign swap = descending ? ($signed(cur_ff) < $signed(rd_data))
                            : ($signed(cur_ff) > $signed(rd_data));

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= es_pkg::ST_IDLE;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         i_ff       <= '0;
         j_ff       <= '0;
         k_ff       <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         i_ff       <= i_in;
         j_ff       <= j_in;
         k_ff       <= k_in;
         strobe_ff  <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      pos_ff  <= pos_in;
      last_ff <= last_in;
      ovf_ff  <= ovf_in;
   end

   // next state, memory requests and result fields
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      cur_in     = cur_ff;
      strobe_in  = 1'b0;
      pos_in     = pos_ff;
      last_in    = last_ff;
      ovf_in     = ovf_ff;
      mem_req    = '0;

      case (state_ff)
         es_pkg::ST_IDLE: begin
            if (start) begin
               // store the element, or note the drop when full
               if (!full) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = es_pkg::ADDR_W'(count_ff);
                  mem_req.wr_data = req_data.value;
                  count_in        = count_ff + es_pkg::CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_data.final_item) begin
                  i_in = '0;
                  k_in = '0;
                  if (n_new == es_pkg::CNT_W'(1)) begin
                     state_in = es_pkg::ST_EMIT;
                  end else begin
                     state_in = es_pkg::ST_LOAD;
                  end
               end
            end
         end

         es_pkg::ST_LOAD: begin
            // fetch element i for the first pass
            mem_req.rd_addr = i_ff;
            state_in        = es_pkg::ST_CUR;
         end

         es_pkg::ST_CUR: begin
            // element i arrives; start scanning at i + 1
            cur_in          = rd_data;
            mem_req.rd_addr = i_ff + es_pkg::ADDR_W'(1);
            j_in            = i_ff + es_pkg::ADDR_W'(1);
            state_in        = es_pkg::ST_SCAN;
         end

         es_pkg::ST_SCAN: begin
            // element j arrives; exchange with the held one when out of order
            if (swap) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = j_ff;
               mem_req.wr_data = cur_ff;
               cur_in          = rd_data;
            end
            mem_req.rd_addr = j_ff + es_pkg::ADDR_W'(1);
            j_in            = j_ff + es_pkg::ADDR_W'(1);
            if (j_ff == n_last) begin
               state_in = es_pkg::ST_WRI;
            end
         end

         es_pkg::ST_WRI: begin
            // retire position i, fetch i + 1 for the next pass
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = i_ff;
            mem_req.wr_data = cur_ff;
            mem_req.rd_addr = i_ff + es_pkg::ADDR_W'(1);
            i_in            = i_ff + es_pkg::ADDR_W'(1);
            if (i_ff + es_pkg::ADDR_W'(1) == n_last) begin
               k_in     = '0;
               state_in = es_pkg::ST_EMIT;
            end else begin
               state_in = es_pkg::ST_CUR;
            end
         end

         es_pkg::ST_EMIT: begin
            // read out one element a cycle; data shows next cycle
            mem_req.rd_addr = k_ff;
            strobe_in       = 1'b1;
            pos_in          = es_pkg::POS_W'(k_ff);
            last_in         = (k_ff == n_last);
            ovf_in          = dropped_ff;
            k_in            = k_ff + es_pkg::ADDR_W'(1);
            if (k_ff == n_last) begin
               count_in   = '0;
               dropped_in = 1'b0;
               state_in   = es_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = es_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy                  = (state_ff != es_pkg::ST_IDLE);
   assign rsp_strobe            = strobe_ff;
   assign rsp_data.sorted_value = $signed(rd_data);
   assign rsp_data.position     = pos_ff;
   assign rsp_data.last_result  = last_ff;
   assign rsp_data.overflow     = ovf_ff;

   // no read and write of the same entry in one cycle while sorting
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (busy && mem_req.wr_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
      else $error("es_ctrl: read and write of the same entry");

   // fill count never passes capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= es_pkg::CNT_W'(es_pkg::CAPACITY))
      else $error("es_ctrl: element count beyond capacity");

   // an element taken while full raises the overflow mark
   a_drop_flag: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && full) |=> dropped_ff)
      else $error("es_ctrl: dropped element not flagged");

   // the last beat of a run is followed by a quiet cycle
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last_result) |=> !rsp_strobe)
      else $error("es_ctrl: beat after the last result");

endmodule

/* rtl/exchange_sorter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exchange_sorter: store-and-sort unit for signed 32-bit values
// Elements enter one beat per cycle (start high, busy low) into a 64-entry
// store; the beat with final_item set ends the set and starts the sort.
// Elements past capacity are dropped and the run is marked overflow.
// The sort is an exchange sort over the single-port-pair store: element i
// sits in a register while entries i+1..n-1 stream past, one per cycle,
// bound by the one read and one write of the store per cycle.
// Readout then gives n result beats on consecutive cycles, each marked by
// rsp_strobe for one cycle, with position, last_result on the final one
// and the overflow mark. Results cannot be held off.
// busy stays high from the final beat until the last read is issued; the
// next set may start in the cycle that carries the last result.
// csr_wr_data selects the order (0 ascending, 1 descending); write it only
// while busy is low and no results are pending.
// Synchronous reset clears the element count and selects ascending order.
// ----------------------------------------------------------------------------
module exchange_sorter (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  es_pkg::req_type req_data,
   output logic            rsp_strobe,
   output es_pkg::rsp_type rsp_data,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data
);

   logic                      descending_ff;
   es_pkg::mem_req_type       mem_req;
   logic [es_pkg::DATA_W-1:0] rd_data;

   // order select register
   always_ff @(posedge clock) begin
      if (reset) begin
         descending_ff <= 1'b0;
      end else if (csr_wr_en) begin
         descending_ff <= csr_wr_data;
      end
   end

   // element store
   es_ram #(
      .WIDTH (es_pkg::DATA_W),
      .DEPTH (es_pkg::CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

   // sequencer
   es_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .descending (descending_ff),
      .rd_data    (rd_data),
      .busy       (busy),
      .mem_req    (mem_req),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
